// ===== sv/pcf_pkg.sv =====
// Shared types and constants for the pump command framer.
`timescale 1ns / 1ps

package pcf_pkg;

  typedef enum logic [1:0] {
    CMD_RUN  = 2'd0,
    CMD_STOP = 2'd1,
    CMD_FLOW = 2'd2,
    CMD_CAL  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    FS_IDLE = 2'd0,
    FS_READ = 2'd1,
    FS_DIV  = 2'd2,
    FS_PUSH = 2'd3
  } front_state_e;

  typedef struct packed {
    cmd_e        command;
    logic [9:0]  flow_rate;
    logic [5:0]  entry_index;
    logic [15:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_start;
    logic       frame_last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  flag;
    logic [15:0] word;
  } frame_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam int SEGMENTS_DEF = 64;

  localparam logic [7:0]  FLAG_RUN  = 8'h52;
  localparam logic [7:0]  FLAG_STOP = 8'h53;
  localparam logic [7:0]  FLAG_FLOW = 8'h46;
  localparam logic [15:0] STEP_MAX  = 16'hFFFF;

  // Segment lookups and table indexes are compared at this width (SEGMENTS <= 1024).
  localparam int IDX_W = 11;

  // floor(x / 10) == (x * 205) >> 11 for every x below 1029.
  localparam logic [17:0] RECIP_10    = 18'd205;
  localparam int          RECIP_SHIFT = 11;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [2:0] BYTE_FLAG = 3'd1;
  localparam logic [2:0] BYTE_HIGH = 3'd2;
  localparam logic [2:0] BYTE_LOW  = 3'd3;
  localparam logic [2:0] BYTE_LAST = 3'd4;

endpackage

// ===== sv/pump_command_framer.sv =====
// Pump command framer: five-byte frames for run, stop and set-flow commands.
// Run and stop requests are pushed to the queue directly on acceptance; set flow is queued
// only after the table read, product and radix-16 division. Bytes leave at one per cycle
// while out_stall is low; the front end stalls its input while it works on a set-flow command.
// Synchronous active-low reset clears the control state and the queue; the calibration
// table is not cleared and holds undefined data until written.
`timescale 1ns / 1ps

module pump_command_framer #(
  parameter int SEGMENTS = pcf_pkg::SEGMENTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pcf_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output pcf_pkg::out_item_t  out_data
);

  logic                push;
  logic                pop;
  pcf_pkg::frame_req_t push_data;
  pcf_pkg::frame_req_t head;
  pcf_pkg::q_stat_t    q_stat;

  pcf_front #(
    .SEGMENTS (SEGMENTS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_stat    (q_stat)
  );

  pcf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  pcf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== sv/pcf_front.sv =====
// Front end: accepts commands, keeps the calibration table and works out the flow step.
`timescale 1ns / 1ps

module pcf_front #(
  parameter int SEGMENTS = pcf_pkg::SEGMENTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pcf_pkg::in_item_t    in_data,
  output logic                 push,
  output pcf_pkg::frame_req_t  push_data,
  input  pcf_pkg::q_stat_t     q_stat
);

  localparam int AW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam logic [pcf_pkg::IDX_W-1:0] SEG_COUNT = pcf_pkg::IDX_W'(SEGMENTS);
  localparam logic [pcf_pkg::IDX_W-1:0] SEG_TOP   = pcf_pkg::IDX_W'(SEGMENTS - 1);

  pcf_pkg::front_state_e state_r, state_nxt;

  logic [15:0] cal_mem [SEGMENTS];
  logic [15:0] rd_data_r;

  logic [9:0]  flow_r;
  logic [10:0] mult10_r;
  logic [10:0] rem_r, rem_nxt;
  logic [15:0] dvd_r, dvd_nxt;
  logic [1:0]  cnt_r;
  logic        sat_r;

  logic        accept;
  logic        is_frame_cmd;
  logic [9:0]  flow_m1;
  logic [17:0] seg_prod;
  logic [6:0]  seg;
  logic [6:0]  seg_p1;
  logic [10:0] mult10;
  logic [pcf_pkg::IDX_W-1:0] seg_ext;
  logic [pcf_pkg::IDX_W-1:0] rd_idx;
  logic [pcf_pkg::IDX_W-1:0] wr_idx;
  logic        wr_en;

  assign accept       = in_valid && !in_stall;
  assign is_frame_cmd = (in_data.command == pcf_pkg::CMD_RUN) ||
                        (in_data.command == pcf_pkg::CMD_STOP);

  // Segment from the flow rate; a zero flow wraps here but saturates later anyway.
  assign flow_m1  = in_data.flow_rate - 10'd1;
  assign seg_prod = {8'd0, flow_m1} * pcf_pkg::RECIP_10;
  assign seg      = seg_prod[pcf_pkg::RECIP_SHIFT +: 7];
  assign seg_p1   = seg + 7'd1;
  assign mult10   = {1'b0, seg_p1, 3'd0} + {3'd0, seg_p1, 1'b0};
  assign seg_ext  = {{(pcf_pkg::IDX_W - 7){1'b0}}, seg};
  assign rd_idx   = (seg_ext >= SEG_COUNT) ? SEG_TOP : seg_ext;
  assign wr_idx   = {{(pcf_pkg::IDX_W - 6){1'b0}}, in_data.entry_index};
  assign wr_en    = accept && (in_data.command == pcf_pkg::CMD_CAL) && (wr_idx < SEG_COUNT);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cal_mem[wr_idx[AW-1:0]] <= in_data.entry_value;
    end
    rd_data_r <= cal_mem[rd_idx[AW-1:0]];
  end

  // Four restoring quotient bits per cycle.
  always_comb begin
    logic [11:0] trial;
    logic [10:0] rem_w;
    logic [15:0] dvd_w;
    rem_w = rem_r;
    dvd_w = dvd_r;
    for (int i = 0; i < 4; i++) begin
      trial = {rem_w, dvd_w[15]};
      dvd_w = {dvd_w[14:0], 1'b0};
      if (trial >= {2'd0, flow_r}) begin
        rem_w    = 11'(trial - {2'd0, flow_r});
        dvd_w[0] = 1'b1;
      end else begin
        rem_w    = trial[10:0];
      end
    end
    rem_nxt = rem_w;
    dvd_nxt = dvd_w;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pcf_pkg::FS_IDLE: begin
        if (accept && (in_data.command == pcf_pkg::CMD_FLOW)) begin
          state_nxt = pcf_pkg::FS_READ;
        end
      end
      pcf_pkg::FS_READ: begin
        state_nxt = pcf_pkg::FS_DIV;
      end
      pcf_pkg::FS_DIV: begin
        if (cnt_r == 2'd3) begin
          state_nxt = pcf_pkg::FS_PUSH;
        end
      end
      pcf_pkg::FS_PUSH: begin
        if (!q_stat.full) begin
          state_nxt = pcf_pkg::FS_IDLE;
        end
      end
      default: begin
        state_nxt = pcf_pkg::FS_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall  = q_stat.full;
    push      = 1'b0;
    push_data = '{flag: pcf_pkg::FLAG_RUN, word: 16'd0};
    case (state_r)
      pcf_pkg::FS_IDLE: begin
        push = in_valid && !q_stat.full && is_frame_cmd;
        if (in_data.command == pcf_pkg::CMD_STOP) begin
          push_data.flag = pcf_pkg::FLAG_STOP;
        end
      end
      pcf_pkg::FS_PUSH: begin
        in_stall  = 1'b1;
        push      = !q_stat.full;
        push_data = '{flag: pcf_pkg::FLAG_FLOW, word: sat_r ? pcf_pkg::STEP_MAX : dvd_r};
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcf_pkg::FS_IDLE;
      cnt_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      if (state_r == pcf_pkg::FS_DIV) begin
        cnt_r <= cnt_r + 2'd1;
      end else begin
        cnt_r <= 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      flow_r   <= in_data.flow_rate;
      mult10_r <= mult10;
    end
    case (state_r)
      pcf_pkg::FS_READ: begin
        {rem_r, dvd_r} <= 27'(rd_data_r * mult10_r);
      end
      pcf_pkg::FS_DIV: begin
        rem_r <= rem_nxt;
        dvd_r <= dvd_nxt;
        // The quotient overflows 16 bits exactly when the upper product bits reach the flow.
        if (cnt_r == 2'd0) begin
          sat_r <= (flow_r == 10'd0) || (rem_r >= {1'b0, flow_r});
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== sv/pcf_queue.sv =====
// Short frame request queue between the front end and the byte serialiser.
`timescale 1ns / 1ps

module pcf_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  pcf_pkg::frame_req_t  push_data,
  input  logic                 pop,
  output pcf_pkg::frame_req_t  head,
  output pcf_pkg::q_stat_t     q_stat
);

  localparam int DEPTH = pcf_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  pcf_pkg::frame_req_t slots [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;

  assign q_stat.full  = (count_r == (PW + 1)'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head         = slots[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== sv/pcf_back.sv =====
// Back end: serialises each frame request into five frame bytes.
`timescale 1ns / 1ps

module pcf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pcf_pkg::frame_req_t  head,
  input  pcf_pkg::q_stat_t     q_stat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pcf_pkg::out_item_t   out_data
);

  pcf_pkg::frame_req_t ent_r;
  logic       active_r;
  logic [2:0] idx_r;
  logic       out_accept;
  logic       at_last;

  assign out_valid  = active_r;
  assign out_accept = active_r && !out_stall;
  assign at_last    = (idx_r == pcf_pkg::BYTE_LAST);
  // A new frame is loaded from a non-empty queue when nothing is held or the last byte leaves this cycle.
  assign pop        = !q_stat.empty && (!active_r || (out_accept && at_last));

  always_comb begin
    out_data.frame_start = (idx_r == 3'd0);
    out_data.frame_last  = at_last;
    case (idx_r)
      pcf_pkg::BYTE_FLAG: out_data.frame_byte = ent_r.flag;
      pcf_pkg::BYTE_HIGH: out_data.frame_byte = ent_r.word[15:8];
      pcf_pkg::BYTE_LOW:  out_data.frame_byte = ent_r.word[7:0];
      default:            out_data.frame_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= 3'd0;
    end else if (pop) begin
      active_r <= 1'b1;
      idx_r    <= 3'd0;
    end else if (out_accept) begin
      if (at_last) begin
        active_r <= 1'b0;
        idx_r    <= 3'd0;
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the pump command framer, with its own frame predictor.
`timescale 1ns / 1ps

module testbench;

  localparam int CLK_PERIOD = 20;
  localparam int SEGMENTS   = pcf_pkg::SEGMENTS_DEF;
  localparam int TAIL_ITEMS = 25;

  typedef struct {
    pcf_pkg::in_item_t item;
    bit                wait_drain;
  } pending_cmd_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  pcf_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  pcf_pkg::out_item_t out_data;

  pending_cmd_t       pending_cmds[$];
  pcf_pkg::out_item_t frames_due[$];
  logic [15:0]        cal_copy[0:SEGMENTS-1];
  bit [63:0]          gen_loaded = '0;

  bit in_taken = 1'b0;
  int in_gap_left = 0;
  int out_hold_left = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int bytes_checked = 0;
  int n_run = 0, n_stop = 0, n_flow = 0, n_cal = 0;

  pump_command_framer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Step value for a set-flow command, from the testbench's own copy of the table.
  function automatic logic [15:0] step_for_flow(logic [9:0] flow);
    int unsigned seg;
    int unsigned idx;
    longint unsigned prod;
    if (flow == 10'd0) return pcf_pkg::STEP_MAX;
    seg = (int'(flow) - 1) / 10;
    idx = (seg >= SEGMENTS) ? SEGMENTS - 1 : seg;
    prod = cal_copy[idx];
    prod = prod * (seg + 1) * 10;
    prod = prod / flow;
    return (prod > 64'd65535) ? pcf_pkg::STEP_MAX : prod[15:0];
  endfunction

  task automatic push_frame(logic [7:0] flag, logic [15:0] word);
    logic [7:0]         bytes[5];
    pcf_pkg::out_item_t b;
    bytes = '{8'h00, flag, word[15:8], word[7:0], 8'h00};
    for (int k = 0; k < 5; k++) begin
      b.frame_byte  = bytes[k];
      b.frame_start = (k == 0);
      b.frame_last  = (k == 4);
      frames_due.push_back(b);
    end
  endtask

  task automatic report_mismatch(string what, pcf_pkg::out_item_t want,
                                 pcf_pkg::out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected byte %h start %b last %b, got byte %h start %b last %b",
               $time, what, want.frame_byte, want.frame_start, want.frame_last,
               got.frame_byte, got.frame_start, got.frame_last);
  endtask

  // Apart from zero, set-flow rates are drawn only from segments whose calibration entry has been loaded.
  function automatic logic [9:0] pick_flow();
    int s;
    if ($urandom_range(0, 19) == 0) return 10'd0;
    if (gen_loaded[SEGMENTS-1] && $urandom_range(0, 9) == 0)
      return 10'($urandom_range(631, 1023));
    do s = $urandom_range(0, SEGMENTS - 1); while (!gen_loaded[s]);
    return 10'(s * 10 + $urandom_range(1, 10));
  endfunction

  task automatic queue_cmd(pcf_pkg::cmd_e c, logic [9:0] flow, logic [5:0] idx,
                           logic [15:0] val, bit drain = 1'b0);
    pending_cmd_t p;
    p.item.command     = c;
    p.item.flow_rate   = flow;
    p.item.entry_index = idx;
    p.item.entry_value = val;
    p.wait_drain       = drain;
    if (c == pcf_pkg::CMD_CAL && idx < SEGMENTS) gen_loaded[idx] = 1'b1;
    pending_cmds.push_back(p);
  endtask

  task automatic queue_random_cmd(bit drain);
    int r;
    logic [9:0]  flow;
    logic [5:0]  idx;
    logic [15:0] val;
    r    = $urandom_range(0, 99);
    flow = 10'($urandom_range(0, 1023));
    idx  = 6'($urandom);
    val  = 16'($urandom);
    if (r < 15) queue_cmd(pcf_pkg::CMD_RUN, flow, idx, val, drain);
    else if (r < 30) queue_cmd(pcf_pkg::CMD_STOP, flow, idx, val, drain);
    else if (r < 50) begin
      case ($urandom_range(0, 7))
        0: val = 16'h0000;
        1: val = 16'hFFFF;
        default: ;
      endcase
      queue_cmd(pcf_pkg::CMD_CAL, flow, idx, val, drain);
    end else begin
      queue_cmd(pcf_pkg::CMD_FLOW, pick_flow(), idx, val, drain);
    end
  endtask

  // Input driver: a new transaction is presented only once the previous one was taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap_left > 0) begin
        in_gap_left <= in_gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_cmds[0].wait_drain && frames_due.size() != 0) begin
        in_valid <= 1'b0;
      end else if (pending_cmds.size() > TAIL_ITEMS && (cycle_count / 64) % 3 != 2
                   && $urandom_range(0, 4) == 0) begin
        in_gap_left <= $urandom_range(0, 5);
        in_valid <= 1'b0;
      end else begin
        in_data  <= pending_cmds[0].item;
        in_valid <= 1'b1;
        pending_cmds.pop_front();
      end
    end
  end

  always @(negedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (out_hold_left > 0) begin
      out_stall <= 1'b1;
      out_hold_left <= out_hold_left - 1;
    end else if (pending_cmds.size() > TAIL_ITEMS && (cycle_count / 64) % 3 != 1
                 && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      out_hold_left <= $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Prediction on each accepted command, and checking of each accepted frame byte.
  always @(posedge clk) begin
    pcf_pkg::out_item_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      case (in_data.command)
        pcf_pkg::CMD_RUN: begin
          push_frame(pcf_pkg::FLAG_RUN, 16'h0000);
          n_run++;
        end
        pcf_pkg::CMD_STOP: begin
          push_frame(pcf_pkg::FLAG_STOP, 16'h0000);
          n_stop++;
        end
        pcf_pkg::CMD_FLOW: begin
          push_frame(pcf_pkg::FLAG_FLOW, step_for_flow(in_data.flow_rate));
          n_flow++;
        end
        pcf_pkg::CMD_CAL: begin
          if (in_data.entry_index < SEGMENTS) cal_copy[in_data.entry_index] = in_data.entry_value;
          n_cal++;
        end
        default: ;
      endcase
    end
    if (rst_n && out_valid && !out_stall) begin
      if (frames_due.size() == 0) begin
        report_mismatch("unexpected frame byte", '0, out_data);
      end else begin
        want = frames_due.pop_front();
        if (out_data.frame_byte !== want.frame_byte || out_data.frame_start !== want.frame_start
            || out_data.frame_last !== want.frame_last)
          report_mismatch("frame byte mismatch", want, out_data);
        bytes_checked++;
      end
    end
  end

  initial begin
    // Directed part: frame kinds, zero flow, table extremes and reads beyond the table.
    queue_cmd(pcf_pkg::CMD_RUN, 10'd0, 6'd0, 16'h0000);
    queue_cmd(pcf_pkg::CMD_STOP, 10'h3FF, 6'h3F, 16'hFFFF);
    queue_cmd(pcf_pkg::CMD_FLOW, 10'd0, 6'h3F, 16'hFFFF);
    queue_cmd(pcf_pkg::CMD_CAL, 10'h3FF, 6'd0, 16'hFFFF);
    queue_cmd(pcf_pkg::CMD_CAL, 10'd0, 6'd1, 16'h0000);
    queue_cmd(pcf_pkg::CMD_CAL, 10'h2AA, 6'd63, 16'h8000);
    queue_cmd(pcf_pkg::CMD_CAL, 10'h155, 6'd5, 16'h0001);
    queue_cmd(pcf_pkg::CMD_CAL, 10'd7, 6'd31, 16'h1234);
    queue_cmd(pcf_pkg::CMD_FLOW, 10'd1, 6'd0, 16'h0000);
    queue_cmd(pcf_pkg::CMD_FLOW, 10'd10, 6'h2A, 16'hA5A5);
    queue_cmd(pcf_pkg::CMD_FLOW, 10'd11, 6'h15, 16'h5A5A);
    queue_cmd(pcf_pkg::CMD_FLOW, 10'd20, 6'd0, 16'hFFFF);
    queue_cmd(pcf_pkg::CMD_FLOW, 10'd51, 6'd0, 16'h0000);
    queue_cmd(pcf_pkg::CMD_FLOW, 10'd60, 6'd0, 16'h0000);
    queue_cmd(pcf_pkg::CMD_FLOW, 10'd315, 6'd0, 16'h0000);
    queue_cmd(pcf_pkg::CMD_FLOW, 10'd640, 6'd0, 16'h0000);
    queue_cmd(pcf_pkg::CMD_FLOW, 10'd641, 6'd0, 16'h0000);
    queue_cmd(pcf_pkg::CMD_FLOW, 10'h3FF, 6'd0, 16'h0000);
    queue_cmd(pcf_pkg::CMD_CAL, 10'd0, 6'd63, 16'h0000);
    queue_cmd(pcf_pkg::CMD_FLOW, 10'h3FF, 6'h3F, 16'hFFFF);
    queue_cmd(pcf_pkg::CMD_RUN, 10'h3FF, 6'h3F, 16'hFFFF);
    queue_cmd(pcf_pkg::CMD_STOP, 10'd0, 6'd0, 16'h0000);
    for (int i = 0; i < 108; i++) queue_random_cmd(i == 45 || i == 95);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || in_valid) @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (frames_due.size() != 0) begin
      mismatches++;
      $display("%0d frame bytes never arrived", frames_due.size());
    end
    $display("Sent %0d run, %0d stop, %0d set-flow and %0d calibration commands;",
             n_run, n_stop, n_flow, n_cal);
    $display("checked %0d frame bytes, %0d mismatches.", bytes_checked, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * 200000);
    $display("Timed out waiting for the run to finish");
    $display("CHECK FAILED");
    $finish;
  end

endmodule
